// File: rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants of the bilevel error diffusion block.
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam int DEFAULT_MAX_WIDTH = 4096;

    localparam int CFG_W      = 13;
    localparam int PIX_W      = 8;
    localparam int LINE_W     = 12;
    localparam int RC_W       = 11;
    localparam int ERR_W      = 9;
    localparam int ACC_W      = 13;
    localparam int LVL_W      = 10;
    localparam int DIV_SHIFT  = 4;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 13'd640;

    localparam int LUMA_SUM_W   = 18;
    localparam int LUMA_RECIP_W = 19;
    localparam int LUMA_SHIFT   = 28;
    localparam logic [LUMA_SUM_W-1:0]   LUMA_WR    = 18'd299;
    localparam logic [LUMA_SUM_W-1:0]   LUMA_WG    = 18'd587;
    localparam logic [LUMA_SUM_W-1:0]   LUMA_WB    = 18'd114;
    // ceil(2^28 / 1000), exact floor division for sums below 2^18
    localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;

    localparam logic signed [ACC_W-1:0] ACC_DIV_BIAS  = 13'sd15;
    localparam logic signed [ACC_W-1:0] ACC_ZERO      = 13'sd0;
    localparam logic signed [LVL_W-1:0] LEVEL_WHITE   = 10'sd255;
    localparam logic signed [LVL_W-1:0] LEVEL_BLACK   = 10'sd0;
    localparam logic signed [LVL_W-1:0] LEVEL_TOP     = 10'sd255;
    localparam logic [PIX_W-1:0]        LEVEL_MAX     = 8'd255;
    localparam logic [PIX_W-1:0]        LEVEL_MIN     = 8'd0;
    localparam logic [PIX_W-1:0]        WHITE_THRESH  = 8'd128;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic sof;
        logic first_row;
        logic row_end;
    } bed_flags_t;

endpackage

// File: rtl/bed_pixel_if.sv
// ----------------------------------------------------------------------------
// bed_pixel_if
// Pixel stream channel: valid/ready handshake with an RGB payload.
// ----------------------------------------------------------------------------
interface bed_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [bed_pkg::PIX_W-1:0] red;
    logic [bed_pkg::PIX_W-1:0] green;
    logic [bed_pkg::PIX_W-1:0] blue;
    logic                      start_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output start_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input start_of_frame, output ready);
endinterface

// File: rtl/bed_result_if.sv
// ----------------------------------------------------------------------------
// bed_result_if
// Result stream channel: valid/ready handshake with the bilevel decision.
// ----------------------------------------------------------------------------
interface bed_result_if;
    logic valid;
    logic ready;
    logic pixel_white;

    modport source (output valid, output pixel_white, input ready);
    modport sink   (input valid, input pixel_white, output ready);
endinterface

// File: rtl/bilevel_error_diffusion.sv
// ----------------------------------------------------------------------------
// bilevel_error_diffusion
// Floyd-Steinberg bilevel ditherer for an RGB pixel stream in raster order.
// ----------------------------------------------------------------------------
// pixel_in carries red, green, blue and start_of_frame; result_out carries
// pixel_white, one result per pixel in input order. Both use valid/ready,
// a transfer happens on a clock edge with valid and ready high.
// cfg_wr_en/cfg_wr_data write line_width (reset 640); write it only while
// no pixel is in flight. Widths outside 1..MAX_WIDTH are clamped.
// Throughput is one pixel per clock while the result queue has room. The
// row error loop closes within the quantizer stage, and the error line
// store is split into even and odd banks so the two writes at a row end
// fit in the same cycle. Each result passes the s1 and s2 registers first.
// A four-entry result queue absorbs receiver stalls; pixel_in.ready drops
// only when the queue plus the two pipeline stages would overflow.
// Reset clears the carries, the column count and sets the first-row flag;
// the line store needs no clearing since the first row never reads it.
// ----------------------------------------------------------------------------
module bilevel_error_diffusion #(
    parameter int MAX_WIDTH = bed_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    bed_pixel_if.sink                 pixel_in,
    bed_result_if.source              result_out,
    input  logic                      cfg_wr_en,
    input  logic [bed_pkg::CFG_W-1:0] cfg_wr_data
);
    import bed_pkg::*;

    localparam int IDXW = $clog2(MAX_WIDTH + 1);

    logic [CFG_W-1:0]         line_width_reg;
    logic                     in_ready;
    logic                     in_fire;

    logic                     rd_en;
    logic [IDXW-1:0]          rd_idx;
    logic signed [LINE_W-1:0] rd_data;
    logic                     s2_valid;
    logic [PIX_W-1:0]         s2_luma;
    logic [IDXW-1:0]          s2_x;
    logic [IDXW-1:0]          s2_w;
    bed_flags_t               s2_flags;

    logic                     wr_a_en;
    logic [IDXW-1:0]          wr_a_idx;
    logic signed [LINE_W-1:0] wr_a_data;
    logic                     wr_b_en;
    logic [IDXW-1:0]          wr_b_idx;
    logic signed [LINE_W-1:0] wr_b_data;

    logic                     res_valid;
    logic                     res_white;
    logic [FIFO_CNT_W-1:0]    fifo_count;
    logic [FIFO_CNT_W-1:0]    in_flight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // reserve queue room for every pixel still in the pipeline
    always_comb
    begin
        in_flight = FIFO_CNT_W'(rd_en) + FIFO_CNT_W'(s2_valid) + fifo_count;
        in_ready  = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));
        in_fire   = pixel_in.valid && in_ready;
    end

    assign pixel_in.ready = in_ready;

    bed_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_fire),
        .red            (pixel_in.red),
        .green          (pixel_in.green),
        .blue           (pixel_in.blue),
        .start_of_frame (pixel_in.start_of_frame),
        .line_width     (line_width_reg),
        .rd_en          (rd_en),
        .rd_idx         (rd_idx),
        .s2_valid       (s2_valid),
        .s2_luma        (s2_luma),
        .s2_x           (s2_x),
        .s2_w           (s2_w),
        .s2_flags       (s2_flags)
    );

    bed_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .wr_a_en   (wr_a_en),
        .wr_a_idx  (wr_a_idx),
        .wr_a_data (wr_a_data),
        .wr_b_en   (wr_b_en),
        .wr_b_idx  (wr_b_idx),
        .wr_b_data (wr_b_data)
    );

    bed_diffuse #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_diffuse (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_luma   (s2_luma),
        .s2_x      (s2_x),
        .s2_w      (s2_w),
        .s2_flags  (s2_flags),
        .rd_data   (rd_data),
        .wr_a_en   (wr_a_en),
        .wr_a_idx  (wr_a_idx),
        .wr_a_data (wr_a_data),
        .wr_b_en   (wr_b_en),
        .wr_b_idx  (wr_b_idx),
        .wr_b_data (wr_b_data),
        .res_valid (res_valid),
        .res_white (res_white)
    );

    bed_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_white (res_white),
        .pop_ready  (result_out.ready),
        .out_valid  (result_out.valid),
        .out_white  (result_out.pixel_white),
        .count      (fifo_count)
    );

    a_pipe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##2 s2_valid)
        else $error("accepted pixel did not reach the quantizer");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result pushed into a full queue");

    a_row_end_banks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_b_en |-> (wr_b_idx == (wr_a_idx + IDXW'(1))))
        else $error("row end writes do not target adjacent entries");

endmodule

// File: rtl/bed_front.sv
// ----------------------------------------------------------------------------
// bed_front
// Column tracking, line store read address and luma pipeline.
// ----------------------------------------------------------------------------
module bed_front #(
    parameter int  MAX_WIDTH = bed_pkg::DEFAULT_MAX_WIDTH,
    localparam int IDXW      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [bed_pkg::PIX_W-1:0]  red,
    input  logic [bed_pkg::PIX_W-1:0]  green,
    input  logic [bed_pkg::PIX_W-1:0]  blue,
    input  logic                       start_of_frame,
    input  logic [bed_pkg::CFG_W-1:0]  line_width,
    output logic                       rd_en,
    output logic [IDXW-1:0]            rd_idx,
    output logic                       s2_valid,
    output logic [bed_pkg::PIX_W-1:0]  s2_luma,
    output logic [IDXW-1:0]            s2_x,
    output logic [IDXW-1:0]            s2_w,
    output bed_pkg::bed_flags_t        s2_flags
);
    import bed_pkg::*;

    localparam int CMPW  = (IDXW > CFG_W) ? IDXW : CFG_W;
    localparam int PRODW = LUMA_SUM_W + LUMA_RECIP_W;

    logic [IDXW-1:0]       col_reg;
    logic [IDXW-1:0]       col_next;
    logic                  first_row_reg;
    logic                  first_row_next;

    logic                  s1_valid_reg;
    logic [LUMA_SUM_W-1:0] s1_sum_reg;
    logic [IDXW-1:0]       s1_x_reg;
    logic [IDXW-1:0]       s1_w_reg;
    bed_flags_t            s1_flags_reg;

    logic                  s2_valid_reg;
    logic [PIX_W-1:0]      s2_luma_reg;
    logic [IDXW-1:0]       s2_x_reg;
    logic [IDXW-1:0]       s2_w_reg;
    bed_flags_t            s2_flags_reg;

    logic [CMPW-1:0]       lw_ext;
    logic [CMPW-1:0]       w_full;
    logic [IDXW-1:0]       w;
    logic [IDXW-1:0]       col_eff;
    logic [IDXW-1:0]       x;
    logic                  first_eff;
    logic                  row_end;
    logic [LUMA_SUM_W-1:0] sum;
    logic [PRODW-1:0]      prod;

    always_comb
    begin
        lw_ext = CMPW'(line_width);
        if (lw_ext == '0)
        begin
            w_full = CMPW'(1);
        end
        else if (lw_ext > CMPW'(MAX_WIDTH))
        begin
            w_full = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_full = lw_ext;
        end
        w         = w_full[IDXW-1:0];
        col_eff   = start_of_frame ? '0 : col_reg;
        first_eff = start_of_frame | first_row_reg;
        // a column past the row end is folded onto the last column
        x         = (col_eff < w) ? col_eff : (w - IDXW'(1));
        row_end   = (x == (w - IDXW'(1)));
        if (row_end)
        begin
            col_next       = '0;
            first_row_next = 1'b0;
        end
        else
        begin
            col_next       = x + IDXW'(1);
            first_row_next = first_eff;
        end
        sum  = LUMA_SUM_W'(red) * LUMA_WR + LUMA_SUM_W'(green) * LUMA_WG
             + LUMA_SUM_W'(blue) * LUMA_WB;
        prod = PRODW'(s1_sum_reg) * PRODW'(LUMA_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg       <= col_next;
                first_row_reg <= first_row_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg             <= sum;
            s1_x_reg               <= x;
            s1_w_reg               <= w;
            s1_flags_reg.sof       <= start_of_frame;
            s1_flags_reg.first_row <= first_eff;
            s1_flags_reg.row_end   <= row_end;
        end
        if (s1_valid_reg)
        begin
            s2_luma_reg  <= prod[LUMA_SHIFT +: PIX_W];
            s2_x_reg     <= s1_x_reg;
            s2_w_reg     <= s1_w_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign rd_en    = s1_valid_reg;
    assign rd_idx   = s1_x_reg + IDXW'(1);
    assign s2_valid = s2_valid_reg;
    assign s2_luma  = s2_luma_reg;
    assign s2_x     = s2_x_reg;
    assign s2_w     = s2_w_reg;
    assign s2_flags = s2_flags_reg;

endmodule

// File: rtl/bed_line_store.sv
// ----------------------------------------------------------------------------
// bed_line_store
// Error line store split into even and odd banks, one write port each,
// one registered read per cycle.
// ----------------------------------------------------------------------------
module bed_line_store #(
    parameter int  MAX_WIDTH = bed_pkg::DEFAULT_MAX_WIDTH,
    localparam int IDXW      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [IDXW-1:0]                   rd_idx,
    output logic signed [bed_pkg::LINE_W-1:0] rd_data,
    input  logic                              wr_a_en,
    input  logic [IDXW-1:0]                   wr_a_idx,
    input  logic signed [bed_pkg::LINE_W-1:0] wr_a_data,
    input  logic                              wr_b_en,
    input  logic [IDXW-1:0]                   wr_b_idx,
    input  logic signed [bed_pkg::LINE_W-1:0] wr_b_data
);
    import bed_pkg::*;

    localparam int BANK_DEPTH = MAX_WIDTH / 2 + 1;
    localparam int BAW        = IDXW - 1;

    logic signed [LINE_W-1:0] mem_even [BANK_DEPTH];
    logic signed [LINE_W-1:0] mem_odd  [BANK_DEPTH];

    logic signed [LINE_W-1:0] even_q_reg;
    logic signed [LINE_W-1:0] odd_q_reg;
    logic                     sel_reg;

    logic                     even_we;
    logic [BAW-1:0]           even_addr;
    logic signed [LINE_W-1:0] even_data;
    logic                     odd_we;
    logic [BAW-1:0]           odd_addr;
    logic signed [LINE_W-1:0] odd_data;

    // the two writes of one pixel always land in opposite banks
    always_comb
    begin
        if (wr_a_en && !wr_a_idx[0])
        begin
            even_we   = 1'b1;
            even_addr = wr_a_idx[IDXW-1:1];
            even_data = wr_a_data;
        end
        else
        begin
            even_we   = wr_b_en && !wr_b_idx[0];
            even_addr = wr_b_idx[IDXW-1:1];
            even_data = wr_b_data;
        end
        if (wr_a_en && wr_a_idx[0])
        begin
            odd_we   = 1'b1;
            odd_addr = wr_a_idx[IDXW-1:1];
            odd_data = wr_a_data;
        end
        else
        begin
            odd_we   = wr_b_en && wr_b_idx[0];
            odd_addr = wr_b_idx[IDXW-1:1];
            odd_data = wr_b_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            mem_even[even_addr] <= even_data;
        end
        if (odd_we)
        begin
            mem_odd[odd_addr] <= odd_data;
        end
        if (rd_en)
        begin
            even_q_reg <= mem_even[rd_idx[IDXW-1:1]];
            odd_q_reg  <= mem_odd[rd_idx[IDXW-1:1]];
            sel_reg    <= rd_idx[0];
        end
    end

    assign rd_data = sel_reg ? odd_q_reg : even_q_reg;

endmodule

// File: rtl/bed_diffuse.sv
// ----------------------------------------------------------------------------
// bed_diffuse
// Quantizer and Floyd-Steinberg error spreading with write forwarding.
// ----------------------------------------------------------------------------
module bed_diffuse #(
    parameter int  MAX_WIDTH = bed_pkg::DEFAULT_MAX_WIDTH,
    localparam int IDXW      = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s2_valid,
    input  logic [bed_pkg::PIX_W-1:0]         s2_luma,
    input  logic [IDXW-1:0]                   s2_x,
    input  logic [IDXW-1:0]                   s2_w,
    input  bed_pkg::bed_flags_t               s2_flags,
    input  logic signed [bed_pkg::LINE_W-1:0] rd_data,
    output logic                              wr_a_en,
    output logic [IDXW-1:0]                   wr_a_idx,
    output logic signed [bed_pkg::LINE_W-1:0] wr_a_data,
    output logic                              wr_b_en,
    output logic [IDXW-1:0]                   wr_b_idx,
    output logic signed [bed_pkg::LINE_W-1:0] wr_b_data,
    output logic                              res_valid,
    output logic                              res_white
);
    import bed_pkg::*;

    logic signed [RC_W-1:0]   rc_reg;
    logic signed [LINE_W-1:0] pb_reg;
    logic signed [ERR_W-1:0]  pbl_reg;

    logic                     fwd_a_en_reg;
    logic [IDXW-1:0]          fwd_a_idx_reg;
    logic signed [LINE_W-1:0] fwd_a_data_reg;
    logic                     fwd_b_en_reg;
    logic [IDXW-1:0]          fwd_b_idx_reg;
    logic signed [LINE_W-1:0] fwd_b_data_reg;

    logic [IDXW-1:0]          rd_idx;
    logic signed [LINE_W-1:0] below_raw;
    logic signed [LINE_W-1:0] below;
    logic signed [RC_W-1:0]   rc_eff;
    logic signed [LINE_W-1:0] pb_eff;
    logic signed [ERR_W-1:0]  pbl_eff;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [ACC_W-1:0]  quot_full;
    logic signed [ERR_W-1:0]  quot;
    logic signed [LVL_W-1:0]  level_raw;
    logic [PIX_W-1:0]         level;
    logic                     white;
    logic signed [LVL_W-1:0]  err_full;
    logic signed [ERR_W-1:0]  err;
    logic signed [LINE_W-1:0] e12;
    logic signed [LINE_W-1:0] e3;
    logic signed [LINE_W-1:0] e5;
    logic signed [RC_W-1:0]   e7;
    logic signed [LINE_W-1:0] pb_new;

    always_comb
    begin
        rd_idx = s2_x + IDXW'(1);
        // a write landing on the same edge as the read is not in rd_data
        if (fwd_a_en_reg && (fwd_a_idx_reg == rd_idx))
        begin
            below_raw = fwd_a_data_reg;
        end
        else if (fwd_b_en_reg && (fwd_b_idx_reg == rd_idx))
        begin
            below_raw = fwd_b_data_reg;
        end
        else
        begin
            below_raw = rd_data;
        end
        below   = s2_flags.first_row ? '0 : below_raw;
        rc_eff  = s2_flags.sof ? '0 : rc_reg;
        pb_eff  = s2_flags.sof ? '0 : pb_reg;
        pbl_eff = s2_flags.sof ? '0 : pbl_reg;

        // divide by 16 rounding toward zero
        acc       = ACC_W'(rc_eff) + ACC_W'(below);
        acc_adj   = acc + (acc[ACC_W-1] ? ACC_DIV_BIAS : ACC_ZERO);
        quot_full = acc_adj >>> DIV_SHIFT;
        quot      = ERR_W'(quot_full);
        level_raw = $signed({2'b00, s2_luma}) + LVL_W'(quot);

        if (level_raw[LVL_W-1])
        begin
            level = LEVEL_MIN;
        end
        else if (level_raw > LEVEL_TOP)
        begin
            level = LEVEL_MAX;
        end
        else
        begin
            level = level_raw[PIX_W-1:0];
        end
        white    = (level > WHITE_THRESH);
        err_full = $signed({2'b00, level}) - (white ? LEVEL_WHITE : LEVEL_BLACK);
        err      = ERR_W'(err_full);

        e12    = LINE_W'(err);
        e3     = (e12 <<< 1) + e12;
        e5     = (e12 <<< 2) + e12;
        e7     = RC_W'((e12 <<< 3) - e12);
        pb_new = e5 + LINE_W'(pbl_eff);
    end

    assign wr_a_en   = s2_valid;
    assign wr_a_idx  = s2_x;
    assign wr_a_data = e3 + pb_eff;
    assign wr_b_en   = s2_valid && s2_flags.row_end;
    assign wr_b_idx  = s2_w;
    assign wr_b_data = pb_new;
    assign res_valid = s2_valid;
    assign res_white = white;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg       <= '0;
            pb_reg       <= '0;
            pbl_reg      <= '0;
            fwd_a_en_reg <= 1'b0;
            fwd_b_en_reg <= 1'b0;
        end
        else
        begin
            if (s2_valid)
            begin
                if (s2_flags.row_end)
                begin
                    rc_reg  <= '0;
                    pb_reg  <= '0;
                    pbl_reg <= '0;
                end
                else
                begin
                    rc_reg  <= e7;
                    pb_reg  <= pb_new;
                    pbl_reg <= err;
                end
            end
            fwd_a_en_reg <= wr_a_en;
            fwd_b_en_reg <= wr_b_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_a_idx_reg  <= wr_a_idx;
        fwd_a_data_reg <= wr_a_data;
        fwd_b_idx_reg  <= wr_b_idx;
        fwd_b_data_reg <= wr_b_data;
    end

endmodule

// File: rtl/bed_out_fifo.sv
// ----------------------------------------------------------------------------
// bed_out_fifo
// Small result queue that decouples the pipeline from receiver stalls.
// ----------------------------------------------------------------------------
module bed_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           push_white,
    input  logic                           pop_ready,
    output logic                           out_valid,
    output logic                           out_white,
    output logic [bed_pkg::FIFO_CNT_W-1:0] count
);
    import bed_pkg::*;

    logic                  data_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  pop;

    always_comb
    begin
        pop        = out_valid && pop_ready;
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_white;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_white = data_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilevel error diffusion block.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, the extreme and clamped widths,
// the white threshold and a width cut in mid-row. A random run follows, in
// phases of random line width and random pixels. A local model of the
// ditherer predicts each decision, and every result transfer is checked in
// order. The pixel and result sides idle at random, and the result side
// holds off long enough to stall the pixel input.
// ----------------------------------------------------------------------------
module tb;

    import bed_pkg::*;

    localparam int MAX_W       = DEFAULT_MAX_WIDTH;
    localparam int PIXEL_COUNT = 1450;
    localparam int HOLD_CYCLES = 40;

    typedef struct packed {
        logic             wr;
        logic [CFG_W-1:0] width;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             sof;
        logic             known;
        logic             white;
    } pixel_row_t;

    localparam int DIRECTED_ROWS = 24;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    bed_pixel_if  pix ();
    bed_result_if res ();

    bilevel_error_diffusion dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_in    (pix),
        .result_out  (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // dither model state
    logic signed [LINE_W-1:0] line_errs [0:MAX_W];
    logic signed [RC_W-1:0]   carry_right    = '0;
    logic signed [LINE_W-1:0] below_acc      = '0;
    logic signed [ERR_W-1:0]  below_left_err = '0;
    logic [CFG_W-1:0]         col            = '0;
    logic                     top_row        = 1'b1;
    logic [CFG_W-1:0]         width_reg      = LINE_WIDTH_RESET;

    bit expected_white_q [$];
    int errors      = 0;
    int sent_count  = 0;
    int tx_idle_pct = 33;
    int rx_idle_pct = 65;
    int hold_reqs   = 0;

    pixel_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
        '{1'b0, 13'd0,    8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
        '{1'b0, 13'd0,    8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1},
        '{1'b1, 13'd1,    8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 1'b0},
        '{1'b0, 13'd0,    8'd129, 8'd129, 8'd129, 1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b1, 13'd0,    8'd255, 8'd0,   8'd0,   1'b1, 1'b1, 1'b0},
        '{1'b0, 13'd0,    8'd0,   8'd255, 8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b1, 13'd8191, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b0},
        '{1'b1, 13'd4096, 8'd200, 8'd10,  8'd90,  1'b1, 1'b1, 1'b0},
        '{1'b1, 13'd4,    8'd130, 8'd130, 8'd130, 1'b1, 1'b1, 1'b1},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd129, 8'd129, 8'd129, 1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd255, 8'd0,   8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b1, 13'd2,    8'd10,  8'd200, 8'd30,  1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd255, 8'd255, 8'd0,   1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 1'b0},
        '{1'b0, 13'd0,    8'd128, 8'd128, 8'd128, 1'b0, 1'b0, 1'b0}
    };

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int clamp_width(input logic [CFG_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_W)
            return MAX_W;
        return int'(v);
    endfunction

    function automatic void clear_row_carries();
        carry_right    = '0;
        below_acc      = '0;
        below_left_err = '0;
        col            = '0;
    endfunction

    function automatic bit dither_pixel(input logic [PIX_W-1:0] r, g, b, input logic sof);
        int w;
        int x;
        int luma;
        int below;
        int level;
        int err;
        int pal;
        if (sof)
        begin
            clear_row_carries();
            top_row = 1'b1;
        end
        w     = clamp_width(width_reg);
        x     = (int'(col) < w) ? int'(col) : w - 1;
        luma  = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
        below = top_row ? 0 : int'(line_errs[x + 1]);
        level = luma + (int'(carry_right) + below) / 16;
        if (level < 0)
            level = 0;
        else if (level > 255)
            level = 255;
        pal = (level > 128) ? 255 : 0;
        err = level - pal;
        line_errs[x]   = LINE_W'(3 * err + int'(below_acc));
        below_acc      = LINE_W'(5 * err + int'(below_left_err));
        below_left_err = ERR_W'(err);
        carry_right    = RC_W'(7 * err);
        if (x + 1 >= w)
        begin
            line_errs[w] = below_acc;
            clear_row_carries();
            top_row = 1'b0;
        end
        else
        begin
            col = CFG_W'(x + 1);
        end
        return pal != 0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // result side: random idling, long hold on request, in-order check
    initial
    begin
        int hold_left;
        int holds_taken;
        bit exp_white;
        hold_left   = 0;
        holds_taken = 0;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (expected_white_q.size() == 0)
                begin
                    report_mismatch("result transfer with no pixel pending");
                end
                else
                begin
                    exp_white = expected_white_q.pop_front();
                    if (res.pixel_white !== exp_white)
                        report_mismatch($sformatf("pixel_white %b, expected %b",
                                                  res.pixel_white, exp_white));
                end
            end
            if (hold_reqs != holds_taken)
            begin
                holds_taken = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                res.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic sof,
                              input logic known, input logic white);
        bit predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid          <= 1'b1;
        pix.red            <= r;
        pix.green          <= g;
        pix.blue           <= b;
        pix.start_of_frame <= sof;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        predicted = dither_pixel(r, g, b, sof);
        expected_white_q.push_back(known ? white : predicted);
        sent_count++;
    endtask

    task automatic drain_results();
        pix.valid <= 1'b0;
        while (expected_white_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_reg = v;
    endtask

    initial
    begin
        pixel_row_t       row;
        logic [PIX_W-1:0] r, g, b;
        logic [CFG_W-1:0] new_width;
        int               mode;
        int               next_mode;
        int               phase_items;
        int               gray;
        bit               sof_first;

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        pix.valid          <= 1'b0;
        pix.red            <= '0;
        pix.green          <= '0;
        pix.blue           <= '0;
        pix.start_of_frame <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.wr)
            begin
                drain_results();
                write_width(row.width);
            end
            send_pixel(row.red, row.green, row.blue, row.sof, row.known, row.white);
        end

        mode = 0;
        while (sent_count < PIXEL_COUNT)
        begin
            drain_results();
            next_mode = (sent_count < PIXEL_COUNT / 3) ? 0 :
                        (sent_count < 2 * PIXEL_COUNT / 3) ? 1 : 2;
            if (next_mode != mode)
            begin
                mode = next_mode;
                tx_idle_pct = (mode == 1) ? 65 : 0;
                rx_idle_pct <= (mode == 1) ? 33 : 0;
                hold_reqs   <= hold_reqs + 1;
            end

            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: new_width = CFG_W'($urandom_range(12, 1));
                6, 7:             new_width = CFG_W'($urandom_range(100, 13));
                8:                new_width = CFG_W'($urandom_range(700, 101));
                default:
                    case ($urandom_range(3))
                        0:       new_width = '0;
                        1:       new_width = CFG_W'(MAX_W);
                        2:       new_width = '1;
                        default: new_width = CFG_W'($urandom_range(8191));
                    endcase
            endcase
            // a wider row would read store entries never written
            sof_first = (clamp_width(new_width) > clamp_width(width_reg)) ||
                        ($urandom_range(1) == 0);
            write_width(new_width);
            phase_items = (clamp_width(new_width) > 700) ? $urandom_range(40, 5)
                                                         : $urandom_range(90, 30);

            for (int i = 0; i < phase_items; i++)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        gray = $urandom_range(136, 120);
                        r = PIX_W'(gray);
                        g = PIX_W'(gray);
                        b = PIX_W'(gray);
                    end
                    1:
                    begin
                        r = $urandom_range(1) ? 8'd255 : 8'd0;
                        g = $urandom_range(1) ? 8'd255 : 8'd0;
                        b = $urandom_range(1) ? 8'd255 : 8'd0;
                    end
                    default:
                    begin
                        r = PIX_W'($urandom_range(255));
                        g = PIX_W'($urandom_range(255));
                        b = PIX_W'($urandom_range(255));
                    end
                endcase
                send_pixel(r, g, b, (i == 0 && sof_first) || ($urandom_range(99) == 0),
                           1'b0, 1'b0);
            end
        end

        pix.valid <= 1'b0;
        while (expected_white_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
